// ===== hw/rtl/bounded_peer_set_assert.svh =====
// assertion macros shared by the bounded peer set checkers
// no dependencies; included by the checker file
`ifndef BOUNDED_PEER_SET_ASSERT_SVH
`define BOUNDED_PEER_SET_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BPS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define BPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/bps_pkg.sv =====
// shared types, widths and action codes for the bounded peer set
// no dependencies; used by all modules of the block
`timescale 1ns / 1ps

package bps_pkg;

   localparam int ACTION_W = 3;
   localparam int KEY_W    = 64;
   localparam int SLOT_W   = 6;
   localparam int CNT_W    = 7;

   localparam int DEF_CAPACITY = 64;
   localparam int DEF_KEY_BITS = 64;

   localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 7'd64;

   localparam logic [ACTION_W-1:0] ACT_INSERT   = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_GET      = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    peer_key;
      logic [SLOT_W-1:0]   slot_index;
   } bps_cmd_type;

   typedef struct packed {
      logic             ok;
      logic [KEY_W-1:0] key_out;
      logic [CNT_W-1:0] entry_count;
   } bps_res_type;

endpackage

// ===== hw/rtl/bps_engine.sv =====
// slot memory and search sequencer of the bounded peer set
// depends on bps_pkg; one comparator walks the stored keys one slot a cycle
`timescale 1ns / 1ps

module bps_engine #(
   parameter int CAPACITY = bps_pkg::DEF_CAPACITY,
   parameter int KEY_BITS = bps_pkg::DEF_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  bps_pkg::bps_cmd_type     cmd,
   input  logic [bps_pkg::CNT_W-1:0] max_entries,
   input  logic                     rsp_free,
   output logic                     idle,
   output logic                     done,
   output bps_pkg::bps_res_type     result
);
   import bps_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int IW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_MOVE,
      ST_GET,
      ST_DONE
   } state_type;

   state_type state_ff;

   logic [ACTION_W-1:0] action_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [IW-1:0]       scan_ff;
   logic [AW-1:0]       cmp_pos_ff;
   logic                cmp_valid_ff;
   logic [AW-1:0]       pos_ff;
   logic                ok_ff;
   logic [KEY_BITS-1:0] key_out_ff;

   logic [KEY_BITS-1:0] mem [CAPACITY];
   logic [KEY_BITS-1:0] rd_data_ff;

   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [KEY_BITS-1:0] wr_data;

   logic [IW-1:0] count_w;
   logic [IW-1:0] max_w;
   logic [IW-1:0] cap_w;
   logic [IW-1:0] lim_w;
   logic [IW-1:0] last_w;
   logic [IW-1:0] slot_w;
   logic          hit;
   logic          scan_more;

   assign count_w   = IW'(count_ff);
   assign max_w     = IW'(max_entries);
   assign cap_w     = IW'(CAPACITY);
   assign lim_w     = (max_w < cap_w) ? max_w : cap_w;
   assign last_w    = count_w - IW'(1);
   assign slot_w    = IW'(cmd.slot_index);
   assign hit       = cmp_valid_ff && (rd_data_ff == key_ff);
   assign scan_more = scan_ff < count_w;

   // memory port steering
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = scan_ff[AW-1:0];
      wr_en   = 1'b0;
      wr_addr = count_w[AW-1:0];
      wr_data = key_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_en   = start && (cmd.action == ACT_GET);
            rd_addr = slot_w[AW-1:0];
         end
         ST_SEARCH: begin
            if (hit) begin
               // fetch the last key to fill the hole on remove
               rd_en   = 1'b1;
               rd_addr = last_w[AW-1:0];
            end else if (scan_more) begin
               rd_en = 1'b1;
            end else begin
               wr_en = (action_ff == ACT_INSERT);
            end
         end
         ST_MOVE: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  action_ff    <= cmd.action;
                  key_ff       <= cmd.peer_key[KEY_BITS-1:0];
                  ok_ff        <= 1'b0;
                  key_out_ff   <= '0;
                  scan_ff      <= '0;
                  cmp_valid_ff <= 1'b0;
                  unique case (cmd.action)
                     ACT_INSERT: begin
                        state_ff <= (count_w < lim_w) ? ST_SEARCH : ST_DONE;
                     end
                     ACT_REMOVE, ACT_CONTAINS: begin
                        state_ff <= ST_SEARCH;
                     end
                     ACT_GET: begin
                        state_ff <= (slot_w < count_w) ? ST_GET : ST_DONE;
                     end
                     ACT_CLEAR: begin
                        count_ff <= '0;
                        ok_ff    <= 1'b1;
                        state_ff <= ST_DONE;
                     end
                     default: begin
                        state_ff <= ST_DONE;
                     end
                  endcase
               end
            end
            ST_SEARCH: begin
               if (hit) begin
                  pos_ff <= cmp_pos_ff;
                  if (action_ff == ACT_REMOVE) begin
                     state_ff <= ST_MOVE;
                  end else begin
                     ok_ff    <= (action_ff == ACT_CONTAINS);
                     state_ff <= ST_DONE;
                  end
               end else if (scan_more) begin
                  scan_ff      <= scan_ff + IW'(1);
                  cmp_pos_ff   <= scan_ff[AW-1:0];
                  cmp_valid_ff <= 1'b1;
               end else begin
                  // key absent: insert appends at the end
                  if (action_ff == ACT_INSERT) begin
                     count_ff <= count_ff + CNT_W'(1);
                     ok_ff    <= 1'b1;
                  end
                  state_ff <= ST_DONE;
               end
            end
            ST_MOVE: begin
               count_ff <= count_ff - CNT_W'(1);
               ok_ff    <= 1'b1;
               state_ff <= ST_DONE;
            end
            ST_GET: begin
               key_out_ff <= rd_data_ff;
               ok_ff      <= 1'b1;
               state_ff   <= ST_DONE;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign idle               = (state_ff == ST_IDLE);
   assign done               = (state_ff == ST_DONE) && rsp_free;
   assign result.ok          = ok_ff;
   assign result.key_out     = KEY_W'(key_out_ff);
   assign result.entry_count = count_ff;

endmodule

// ===== hw/rtl/bounded_peer_set.sv =====
// bounded peer set top level: handshakes, limit register, result register
// depends on bps_pkg and bps_engine
//
//   port group   direction   handshake             contents
//   req_*        in          req_valid/req_stall   action, peer key, slot index
//   rsp_*        out         rsp_valid/rsp_stall   ok, key out, entry count
//   csr_*        in          csr_wr_en             max_entries limit
//
// one transaction at a time; insert, remove and contains walk the stored keys
// with one comparator, one slot per cycle, a rate set by the slot memory port;
// get reads the addressed slot, and clear and refused transactions need no search.
// reset empties the set and loads a limit of 64; no memory clearing is needed.
// a finished result waits in the output register while rsp_stall is high,
// and the next transaction is taken once the result has left the sequencer.
`timescale 1ns / 1ps

module bounded_peer_set #(
   parameter int CAPACITY = bps_pkg::DEF_CAPACITY,
   parameter int KEY_BITS = bps_pkg::DEF_KEY_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bps_pkg::ACTION_W-1:0] req_action,
   input  logic [bps_pkg::KEY_W-1:0]    req_peer_key,
   input  logic [bps_pkg::SLOT_W-1:0]   req_slot_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_ok,
   output logic [bps_pkg::KEY_W-1:0]    rsp_key_out,
   output logic [bps_pkg::CNT_W-1:0]    rsp_entry_count,
   input  logic                         csr_wr_en,
   input  logic [bps_pkg::CNT_W-1:0]    csr_wr_data
);
   import bps_pkg::*;

   logic [CNT_W-1:0] max_entries_val_ff;
   logic             rsp_valid_ff;
   bps_res_type      rsp_data_ff;

   bps_cmd_type cmd;
   bps_res_type result;
   logic        engine_idle;
   logic        engine_done;
   logic        rsp_free;
   logic        start;

   assign cmd.action     = req_action;
   assign cmd.peer_key   = req_peer_key;
   assign cmd.slot_index = req_slot_index;

   assign req_stall = !engine_idle;
   assign start     = req_valid && engine_idle;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_val_ff <= MAX_ENTRIES_RESET;
      end else if (csr_wr_en) begin
         max_entries_val_ff <= csr_wr_data;
      end
   end

   bps_engine #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (cmd),
      .max_entries (max_entries_val_ff),
      .rsp_free    (rsp_free),
      .idle        (engine_idle),
      .done        (engine_done),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (engine_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (engine_done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_data_ff.ok;
   assign rsp_key_out     = rsp_data_ff.key_out;
   assign rsp_entry_count = rsp_data_ff.entry_count;

endmodule

// ===== hw/rtl/bps_checker.sv =====
// port-level checks for the bounded peer set, bound to the top level
// depends on bps_pkg and bounded_peer_set_assert.svh
`timescale 1ns / 1ps

`include "bounded_peer_set_assert.svh"

module bps_checker #(
   parameter int CAPACITY = bps_pkg::DEF_CAPACITY
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic                         rsp_ok,
   input logic [bps_pkg::KEY_W-1:0]    rsp_key_out,
   input logic [bps_pkg::CNT_W-1:0]    rsp_entry_count
);
   import bps_pkg::*;

   logic                     prev_rsp_valid_ff;
   logic                     req_accept;
   logic                     rsp_rise;
   logic                     count_ok;
   logic                     rsp_fail;
   logic                     key_zero;
   logic                     rsp_wait;
   logic [KEY_W+CNT_W+1:0]   rsp_word;

   always_ff @(posedge clock) begin
      prev_rsp_valid_ff <= rsp_valid;
   end

   assign req_accept = req_valid && !req_stall;
   assign rsp_rise   = rsp_valid && !prev_rsp_valid_ff;
   assign count_ok   = int'(rsp_entry_count) <= CAPACITY;
   assign rsp_fail   = rsp_valid && !rsp_ok;
   assign key_zero   = (rsp_key_out == '0);
   assign rsp_wait   = rsp_valid && rsp_stall;
   assign rsp_word   = {rsp_valid, rsp_ok, rsp_key_out, rsp_entry_count};

   // one transaction in flight: busy right after an accept
   `BPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept, req_stall, "double accept")

   // a new result only appears while a transaction was being worked on
   `BPS_ASSERT_NOW(a_rsp_from_work, clock, reset, rsp_rise, $past(req_stall), "stray result")

   `BPS_ASSERT_NOW(a_count_bound, clock, reset, rsp_valid, count_ok, "count above capacity")

   `BPS_ASSERT_NOW(a_key_only_when_ok, clock, reset, rsp_fail, key_zero, "key on failed result")

   `BPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, $stable(rsp_word), "stalled result moved")

endmodule

bind bounded_peer_set bps_checker #(.CAPACITY(CAPACITY)) u_bps_checker (.*);
